### rtl/core/lpsp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the string pool.
`default_nettype none

package lpsp_pkg;

	// store geometry
	localparam int POOL_BYTES = 4096;
	localparam int ADDR_W     = $clog2(POOL_BYTES);

	// fixed field widths
	localparam int CFG_W   = 13;
	localparam int OP_W    = 3;
	localparam int LEN_W   = 12;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 11;
	localparam int OFF_W   = 12;
	localparam int STAT_W  = 2;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 40;

	// arithmetic widths
	localparam int CMP_W   = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 2;
	localparam int WALK_W  = ((ADDR_W > 16) ? ADDR_W : 16) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR     = 3'd0,
		OP_BEGIN_ADD = 3'd1,
		OP_ADD_BYTE  = 3'd2,
		OP_GET       = 3'd3,
		OP_READ_BYTE = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic latch;       // take the beat's fields, reset walk and result
		logic clear_start; // load header, reset pointers, restart sweep
		logic sweep_wr;    // clearing pass write
		logic set_full;
		logic ba_lo;       // record length low byte
		logic ba_hi;       // record length high byte, pointer update
		logic add_wr;
		logic rd_i;        // read low length byte at walk pointer
		logic rd_i1;       // read high length byte, capture low
		logic get_step;
		logic set_found;
		logic set_miss;
		logic rd_boff;
		logic set_data;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic ba_full;
		logic bl_nz;
		logic walk;
		logic at_idx;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/lpsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/lpsp_dp.sv
// Datapath: byte store, pool pointers, record walk, result staging and output register.
`default_nettype none

module lpsp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpsp_pkg::cmd_t                  cmd,
	output lpsp_pkg::sts_t                  sts,
	input  logic [lpsp_pkg::LEN_W-1:0]      in_string_length,
	input  logic [lpsp_pkg::BYTE_W-1:0]     in_data_byte,
	input  logic [lpsp_pkg::IDX_W-1:0]      in_record_index,
	input  logic [lpsp_pkg::OFF_W-1:0]      in_byte_offset,
	input  logic                            cfg_valid,
	input  logic [lpsp_pkg::CFG_W-1:0]      cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lpsp_pkg::STAT_W-1:0]     out_status,
	output logic [lpsp_pkg::OFF_W-1:0]      out_offset,
	output logic [lpsp_pkg::OFF_W-1:0]      out_stored_length,
	output logic [lpsp_pkg::BYTE_W-1:0]     out_read_data
);

	import lpsp_pkg::*;

	// configuration and pool state
	logic [CFG_W-1:0]  pool_size_q;
	logic [ADDR_W-1:0] hdr_q;
	logic [ADDR_W-1:0] eo_q;
	logic [ADDR_W-1:0] wp_q;
	logic [LEN_W-1:0]  bl_q;
	logic [ADDR_W-1:0] sweep_q;

	// latched beat fields
	logic [LEN_W-1:0]  slen_q;
	logic [BYTE_W-1:0] data_q;
	logic [IDX_W-1:0]  idx_q;
	logic [OFF_W-1:0]  boff_q;

	// record walk
	logic [WALK_W-1:0] i_q;
	logic [IDX_W-1:0]  n_q;
	logic [BYTE_W-1:0] lo_q;

	// result staging and output register
	status_t           res_status_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [OFF_W-1:0]  res_len_q;
	logic [BYTE_W-1:0] res_data_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [OFF_W-1:0]  out_off_q;
	logic [OFF_W-1:0]  out_len_q;
	logic [BYTE_W-1:0] out_data_q;

	// memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic [15:0]       hdr16;
	logic [15:0]       slen1;
	logic [CMP_W-1:0]  ba_need;
	logic [WALK_W-1:0] i1;
	logic              lo_ok;
	logic              hi_ok;
	logic              boff_ok;
	logic [15:0]       len16;
	logic [ADDR_W-1:0] hdr_new;

	assign hdr16   = 16'(hdr_q);
	assign slen1   = 16'(slen_q) + 16'd1;
	assign ba_need = CMP_W'(slen_q) + CMP_W'(3) + CMP_W'(eo_q);
	assign i1      = i_q + WALK_W'(1);
	assign lo_ok   = i_q < WALK_W'(POOL_BYTES);
	assign hi_ok   = i1 < WALK_W'(POOL_BYTES);
	assign boff_ok = int'(boff_q) < POOL_BYTES;
	assign len16   = {(hi_ok ? ram_rdata : 8'h00), lo_q};

	// header = size clamped to 4..store size, less two
	always_comb begin
		if (int'(pool_size_q) > POOL_BYTES) begin
			hdr_new = ADDR_W'(POOL_BYTES - 2);
		end else if (int'(pool_size_q) < 4) begin
			hdr_new = ADDR_W'(2);
		end else begin
			hdr_new = ADDR_W'(pool_size_q - CFG_W'(2));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = '0;
		if (cmd.sweep_wr) begin
			ram_we = 1'b1;
			if (sweep_q == ADDR_W'(0)) begin
				ram_wdata = hdr16[7:0];
			end else if (sweep_q == ADDR_W'(1)) begin
				ram_wdata = hdr16[15:8];
			end
		end else if (cmd.ba_lo) begin
			ram_we    = 1'b1;
			ram_waddr = eo_q;
			ram_wdata = slen1[7:0];
		end else if (cmd.ba_hi) begin
			ram_we    = 1'b1;
			ram_waddr = eo_q + ADDR_W'(1);
			ram_wdata = slen1[15:8];
		end else if (cmd.add_wr) begin
			ram_we    = 1'b1;
			ram_waddr = wp_q;
			ram_wdata = data_q;
		end
	end

	always_comb begin
		ram_raddr = '0;
		if (cmd.rd_i) begin
			ram_raddr = i_q[ADDR_W-1:0];
		end else if (cmd.rd_i1) begin
			ram_raddr = i1[ADDR_W-1:0];
		end else if (cmd.rd_boff) begin
			ram_raddr = ADDR_W'(boff_q);
		end
	end

	lpsp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (POOL_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= CFG_W'(POOL_BYTES);
			hdr_q       <= '0;
			eo_q        <= ADDR_W'(2);
			wp_q        <= '0;
			bl_q        <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_size_q <= cfg_data;
			end
			if (cmd.clear_start) begin
				hdr_q   <= hdr_new;
				eo_q    <= ADDR_W'(2);
				wp_q    <= '0;
				bl_q    <= '0;
				sweep_q <= '0;
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (cmd.ba_hi) begin
				wp_q <= eo_q + ADDR_W'(2);
				bl_q <= slen_q;
				eo_q <= ADDR_W'(ba_need);
			end
			if (cmd.add_wr) begin
				wp_q <= wp_q + ADDR_W'(1);
				bl_q <= bl_q - LEN_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			slen_q       <= in_string_length;
			data_q       <= in_data_byte;
			idx_q        <= in_record_index;
			boff_q       <= in_byte_offset;
			i_q          <= WALK_W'(2);
			n_q          <= '0;
			res_status_q <= ST_OK;
			res_off_q    <= '0;
			res_len_q    <= '0;
			res_data_q   <= '0;
		end
		if (cmd.set_full) begin
			res_status_q <= ST_FULL;
		end
		if (cmd.ba_lo) begin
			res_status_q <= ST_OK;
			res_off_q    <= OFF_W'(eo_q);
		end
		if (cmd.rd_i1) begin
			lo_q <= lo_ok ? ram_rdata : 8'h00;
		end
		if (cmd.get_step) begin
			i_q <= i_q + WALK_W'(2) + WALK_W'(len16);
			n_q <= n_q + IDX_W'(1);
		end
		if (cmd.set_found) begin
			res_status_q <= ST_OK;
			res_off_q    <= OFF_W'(i_q + WALK_W'(2));
			res_len_q    <= OFF_W'(len16);
		end
		if (cmd.set_miss) begin
			res_status_q <= ST_NOT_FOUND;
		end
		if (cmd.set_data) begin
			res_data_q <= boff_ok ? ram_rdata : 8'h00;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
			out_len_q    <= res_len_q;
			out_data_q   <= res_data_q;
		end
	end

	assign sts.sweep_last = sweep_q == ADDR_W'(POOL_BYTES - 1);
	assign sts.ba_full    = ba_need >= CMP_W'(hdr_q);
	assign sts.bl_nz      = bl_q != '0;
	assign sts.walk       = (n_q < idx_q) && (i_q < WALK_W'(hdr_q));
	assign sts.at_idx     = n_q == idx_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_offset        = out_off_q;
	assign out_stored_length = out_len_q;
	assign out_read_data     = out_data_q;

	// an open record always ends one terminator short of the end offset
	a_open_record: assert property (@(posedge clk) disable iff (!arst_n)
		(bl_q != '0) |-> (CMP_W'(wp_q) + CMP_W'(bl_q) + CMP_W'(1) == CMP_W'(eo_q)))
		else $error("open record pointers out of step");

	// a committed record stays inside the header size
	a_end_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ba_hi |=> (eo_q < hdr_q))
		else $error("end offset past pool size");

	// output register never overwritten while a beat waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote pending beat");

	// single store write source per cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep_wr, cmd.ba_lo, cmd.ba_hi, cmd.add_wr}))
		else $error("conflicting store writes");

endmodule

`default_nettype wire

### rtl/core/lpsp_ctrl.sv
// Controller: sequences clearing pass, record append, record walk and byte reads.
`default_nettype none

module lpsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lpsp_pkg::op_t  in_op,
	input  lpsp_pkg::sts_t sts,
	output lpsp_pkg::cmd_t cmd
);

	import lpsp_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_BA_CHECK,
		S_BA_HI,
		S_ADD,
		S_GET_TEST,
		S_GET_LO,
		S_GET_HI,
		S_RD_ISSUE,
		S_RD_CAP,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   walk_q, walk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			walk_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		walk_d   = walk_q;
		in_ready = state_q == S_IDLE;
		case (state_q)
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (in_op)
						OP_CLEAR: begin
							cmd.clear_start = 1'b1;
							state_d         = S_SWEEP;
						end
						OP_BEGIN_ADD: state_d = S_BA_CHECK;
						OP_ADD_BYTE:  state_d = S_ADD;
						OP_GET:       state_d = S_GET_TEST;
						OP_READ_BYTE: state_d = S_RD_ISSUE;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_BA_CHECK: begin
				if (sts.ba_full) begin
					cmd.set_full = 1'b1;
					state_d      = S_RESULT;
				end else begin
					cmd.ba_lo = 1'b1;
					state_d   = S_BA_HI;
				end
			end
			S_BA_HI: begin
				cmd.ba_hi = 1'b1;
				state_d   = S_RESULT;
			end
			S_ADD: begin
				cmd.add_wr = sts.bl_nz;
				state_d    = S_IDLE;
			end
			S_GET_TEST: begin
				if (sts.walk || sts.at_idx) begin
					cmd.rd_i = 1'b1;
					walk_d   = sts.walk;
					state_d  = S_GET_LO;
				end else begin
					cmd.set_miss = 1'b1;
					state_d      = S_RESULT;
				end
			end
			S_GET_LO: begin
				cmd.rd_i1 = 1'b1;
				state_d   = S_GET_HI;
			end
			S_GET_HI: begin
				if (walk_q) begin
					cmd.get_step = 1'b1;
					state_d      = S_GET_TEST;
				end else begin
					cmd.set_found = 1'b1;
					state_d       = S_RESULT;
				end
			end
			S_RD_ISSUE: begin
				cmd.rd_boff = 1'b1;
				state_d     = S_RD_CAP;
			end
			S_RD_CAP: begin
				cmd.set_data = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/length_prefixed_string_pool.sv
// Top level of the length-prefixed string pool: stream ports, controller and datapath.
// Usage
//  - s_axis carries one command beat: clear, begin_add, add_byte, get or read_byte.
//    begin_add, get and read_byte each give exactly one m_axis beat; clear,
//    add_byte and unused op codes give none.
//  - cfg_* writes pool_size; always ready, meant to be written while idle.
//  - One command is worked on at a time; s_axis_tready is high only when the
//    controller is idle.
// Steps per command (input beat to ready again)
//  - unused codes: dropped while idle. add_byte: byte written if the record is open.
//  - read_byte: store read, then byte capture. begin_add: room check with the low
//    length byte, then the high byte, unless full. get: the record walk reads
//    each 16-bit length one byte at a time through the single store read port.
//  - clear: one store byte written per cycle by the clearing pass.
// Reset: the same clearing pass runs (s_axis_tready low), leaving
//  the store zeroed with a zero header; config writes are still taken.
// Back-pressure
//  - A finished result sits in the output register until m_axis_tready; the next
//    command is accepted meanwhile, and a later result waits in a staging register
//    until the output beat is taken.
`default_nettype none

module length_prefixed_string_pool (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// op[2:0], string_length[14:3], data_byte[22:15], record_index[33:23],
	// byte_offset[45:34], zero pad[47:46]
	input  logic [lpsp_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[1:0], offset[13:2], stored_length[25:14], read_data[33:26],
	// zero pad[39:34]
	output logic [lpsp_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpsp_pkg::CFG_W-1:0]    cfg_data
);

	import lpsp_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	op_t               in_op;
	logic [STAT_W-1:0] out_status;
	logic [OFF_W-1:0]  out_offset;
	logic [OFF_W-1:0]  out_stored_length;
	logic [BYTE_W-1:0] out_read_data;

	assign in_op     = op_t'(s_axis_tdata[2:0]);
	assign cfg_ready = 1'b1;

	lpsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (in_op),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpsp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_string_length  (s_axis_tdata[14:3]),
		.in_data_byte      (s_axis_tdata[22:15]),
		.in_record_index   (s_axis_tdata[33:23]),
		.in_byte_offset    (s_axis_tdata[45:34]),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_status        (out_status),
		.out_offset        (out_offset),
		.out_stored_length (out_stored_length),
		.out_read_data     (out_read_data)
	);

	assign m_axis_tdata = {6'b0, out_read_data, out_stored_length, out_offset, out_status};

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the length-prefixed string pool: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
	import lpsp_pkg::*;

	// op codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	// a clear sweeps the whole store, one byte a cycle; wait that out before a register write
	localparam int SETTLE_CYCLES  = 4200;
	localparam int CYCLE_LIMIT    = 25_000_000;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 115;
	localparam int PRINT_CAP      = 40;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  slen;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic [OFF_W-1:0]  boff;
	} pool_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  stored_len;
		logic [BYTE_W-1:0] read_data;
	} pool_reply_t;

	// one line of the directed table; want is only used where typed is set
	typedef struct packed {
		pool_cmd_t   cmd;
		logic        typed;
		pool_reply_t want;
	} pool_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data      = '0;

	length_prefixed_string_pool DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the pool, kept in step with every accepted beat
	// ------------------------------------------------------------------
	logic [7:0]   shadow_store [POOL_BYTES];
	int unsigned  shadow_end;
	int unsigned  shadow_wptr;
	int unsigned  shadow_left;
	int unsigned  shadow_size;
	int unsigned  shadow_records;  // records added since the last clear, steers get indexes

	pool_reply_t  expected_replies [$];
	pool_row_t    directed_rows [$];
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	int           burst_left     = 1;

	// out-of-store reads give zero, which also covers half a length at the top byte
	function automatic int unsigned shadow_byte(input int unsigned a);
		if (a < POOL_BYTES)
			return 32'(shadow_store[a]);
		return 0;
	endfunction

	function automatic int unsigned shadow_half(input int unsigned a);
		return shadow_byte(a) | (shadow_byte(a + 1) << 8);
	endfunction

	task automatic shadow_put(input int unsigned a, input int unsigned v);
		if (a < POOL_BYTES)
			shadow_store[a] = 8'(v);
	endtask

	task automatic reset_shadow();
		for (int a = 0; a < POOL_BYTES; a++) shadow_store[a] = '0;
		shadow_end     = 2;
		shadow_wptr    = 0;
		shadow_left    = 0;
		shadow_size    = POOL_BYTES;
		shadow_records = 0;
	endtask

	// works out what one command does to the pool and which result beat it gives
	task automatic apply_to_shadow(input pool_cmd_t c, output bit gives, output pool_reply_t r);
		int unsigned hdr;
		int unsigned i;
		int unsigned n;
		int unsigned sz;
		r     = '0;
		gives = 1'b0;
		case (c.op)
			OP_CLEAR: begin
				for (int a = 0; a < POOL_BYTES; a++) shadow_store[a] = '0;
				// register value clamped to 4..store size
				sz = shadow_size;
				if (sz > POOL_BYTES)
					sz = POOL_BYTES;
				if (sz < 4)
					sz = 4;
				shadow_put(0, sz - 2);
				shadow_put(1, (sz - 2) >> 8);
				shadow_end     = 2;
				shadow_wptr    = 0;
				shadow_left    = 0;
				shadow_records = 0;
			end
			OP_BEGIN_ADD: begin
				gives = 1'b1;
				hdr   = shadow_half(0);
				i     = shadow_end;
				if (c.slen + 3 + i >= hdr) begin
					r.status = ST_FULL;
				end else begin
					shadow_put(i, c.slen + 1);
					shadow_put(i + 1, (c.slen + 1) >> 8);
					shadow_wptr    = i + 2;
					shadow_left    = 32'(c.slen);
					shadow_end     = i + 3 + c.slen;
					shadow_records = shadow_records + 1;
					r.status       = ST_OK;
					r.offset       = OFF_W'(i);
				end
			end
			OP_ADD_BYTE: begin
				if (shadow_left != 0) begin
					shadow_put(shadow_wptr, 32'(c.data));
					shadow_wptr = shadow_wptr + 1;
					shadow_left = shadow_left - 1;
				end
			end
			OP_GET: begin
				// the walk runs on through empty space, reading it as zero-length records
				gives = 1'b1;
				hdr   = shadow_half(0);
				i     = 2;
				n     = 0;
				while (n < c.idx && i < hdr) begin
					i = i + 2 + shadow_half(i);
					n = n + 1;
				end
				if (n != c.idx) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status     = ST_OK;
					r.offset     = OFF_W'(i + 2);
					r.stored_len = LEN_W'(shadow_half(i));
				end
			end
			OP_READ_BYTE: begin
				gives       = 1'b1;
				r.status    = ST_OK;
				r.read_data = BYTE_W'(shadow_byte(32'(c.boff)));
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Drivers: everything changes on the falling edge
	// ------------------------------------------------------------------

	// all fields random, so that unused fields toggle every bit as well
	function automatic pool_cmd_t random_command();
		pool_cmd_t c;
		c.op   = OP_W'($urandom);
		c.slen = LEN_W'($urandom);
		c.data = BYTE_W'($urandom);
		c.idx  = IDX_W'($urandom);
		c.boff = OFF_W'($urandom);
		return c;
	endfunction

	// one command beat; valid stays high into the next beat unless the burst ends here
	task automatic send_cmd(input pool_cmd_t c, input bit typed, input pool_reply_t want);
		bit          gives;
		pool_reply_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, c.boff, c.idx, c.data, c.slen, c.op};
		do @(posedge clk); while (!s_axis_tready);
		apply_to_shadow(c, gives, r);
		if (gives)
			expected_replies.push_back(typed ? want : r);
		@(negedge clk);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 24);
		end
	endtask

	// pool_size only takes effect at the next clear
	task automatic write_pool_size(input int unsigned v);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		shadow_size = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every result is in, then lets a clear finish its sweep
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// field goes to whichever field the op uses; the rest stay random
	task automatic table_row(input logic [OP_W-1:0] op, input int unsigned field = 0,
	                         input bit typed = 1'b0, input logic [STAT_W-1:0] st = ST_OK,
	                         input int unsigned off = 0, input int unsigned len = 0,
	                         input int unsigned rd = 0);
		pool_row_t row;
		row.cmd    = random_command();
		row.cmd.op = op;
		case (op)
			OP_BEGIN_ADD: row.cmd.slen = LEN_W'(field);
			OP_ADD_BYTE:  row.cmd.data = BYTE_W'(field);
			OP_GET:       row.cmd.idx  = IDX_W'(field);
			OP_READ_BYTE: row.cmd.boff = OFF_W'(field);
			default: ;
		endcase
		row.typed           = typed;
		row.want.status     = st;
		row.want.offset     = OFF_W'(off);
		row.want.stored_len = LEN_W'(len);
		row.want.read_data  = BYTE_W'(rd);
		directed_rows.push_back(row);
	endtask

	// random mix: mostly whole records (begin_add then its string bytes), lookups and
	// reads near the used area, and some noise
	task automatic run_phase(input int items);
		int          sent;
		int          pick;
		int          nbytes;
		pool_cmd_t   c;
		pool_reply_t none;
		none = '0;
		sent = 0;
		while (sent < items) begin
			c    = random_command();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				c.op   = OP_BEGIN_ADD;
				c.slen = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(13, 200))
				                                     : LEN_W'($urandom_range(0, 12));
				send_cmd(c, 1'b0, none);
				sent++;
				nbytes = (shadow_left > 220) ? 220 : int'(shadow_left);
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(0, nbytes);  // string cut short
				else if ($urandom_range(0, 9) == 0)
					nbytes++;                           // one byte too many
				repeat (nbytes) begin
					c    = random_command();
					c.op = OP_ADD_BYTE;
					send_cmd(c, 1'b0, none);
					sent++;
				end
			end else if (pick < 55) begin
				c.op = OP_GET;
				// rarely a wild index, which walks far through empty space
				if ($urandom_range(0, 32) != 0)
					c.idx = IDX_W'($urandom_range(0, shadow_records + 1));
				send_cmd(c, 1'b0, none);
				sent++;
			end else if (pick < 78) begin
				c.op = OP_READ_BYTE;
				if ($urandom_range(0, 4) != 0)
					c.boff = OFF_W'($urandom_range(0, shadow_end + 2));
				send_cmd(c, 1'b0, none);
				sent++;
			end else if (pick < 88) begin
				// any length: mostly full, sometimes a huge record
				c.op = OP_BEGIN_ADD;
				send_cmd(c, 1'b0, none);
				sent++;
			end else if (pick < 94) begin
				c.op = OP_ADD_BYTE;
				send_cmd(c, 1'b0, none);
				sent++;
			end else if (pick < 98) begin
				c.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				send_cmd(c, 1'b0, none);
				sent++;
			end else begin
				c.op = OP_CLEAR;
				send_cmd(c, 1'b0, none);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: ready pattern switches among four modes, each held for a random number of cycles
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
			2:       m_axis_tready <= (stall_left[1:0] == 2'd0);
			default: m_axis_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result check: every result beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		pool_reply_t got;
		pool_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status     = m_axis_tdata[1:0];
			got.offset     = m_axis_tdata[13:2];
			got.stored_len = m_axis_tdata[25:14];
			got.read_data  = m_axis_tdata[33:26];
			if (expected_replies.size() == 0) begin
				flag_mismatch($sformatf("result beat %h with nothing outstanding", m_axis_tdata));
			end else begin
				want = expected_replies.pop_front();
				if (got.status != want.status)
					flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.offset != want.offset)
					flag_mismatch($sformatf("offset %0d, want %0d", got.offset, want.offset));
				if (got.stored_len != want.stored_len)
					flag_mismatch($sformatf("stored_length %0d, want %0d",
					                        got.stored_len, want.stored_len));
				if (got.read_data != want.read_data)
					flag_mismatch($sformatf("read_data %h, want %h",
					                        got.read_data, want.read_data));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned sz;
		pool_cmd_t   clr;
		pool_reply_t none;
		none = '0;
		reset_shadow();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// taken even while the post-reset sweep runs
		write_pool_size(POOL_BYTES);

		// no clear yet: header reads as zero, so adds are full
		table_row(OP_BEGIN_ADD, 5, 1'b1, ST_FULL);
		table_row(OP_READ_BYTE, 4095, 1'b1, ST_OK, 0, 0, 0);
		table_row(OP_GET, 0, 1'b1, ST_OK, 4, 0);
		table_row(OP_GET, 2047, 1'b1, ST_NOT_FOUND);
		table_row(OP_SPARE_FIRST);
		table_row(OP_SPARE_FIRST + 3'd1);
		table_row(OP_SPARE_LAST);
		table_row(OP_ADD_BYTE, 8'h5a);                 // nothing left to fill: dropped
		table_row(OP_CLEAR);
		table_row(OP_READ_BYTE, 0, 1'b1, ST_OK, 0, 0, 8'hfe);  // header 4094, low byte
		table_row(OP_READ_BYTE, 1, 1'b1, ST_OK, 0, 0, 8'h0f);
		table_row(OP_BEGIN_ADD, 3, 1'b1, ST_OK, 2);
		table_row(OP_ADD_BYTE, 8'hff);
		table_row(OP_ADD_BYTE, 8'h00);
		table_row(OP_ADD_BYTE, 8'ha5);
		table_row(OP_GET, 0, 1'b1, ST_OK, 4, 4);
		table_row(OP_READ_BYTE, 4, 1'b1, ST_OK, 0, 0, 8'hff);
		table_row(OP_READ_BYTE, 7, 1'b1, ST_OK, 0, 0, 8'h00);  // terminator
		table_row(OP_BEGIN_ADD, 0, 1'b1, ST_OK, 8);             // empty string
		table_row(OP_GET, 1, 1'b1, ST_OK, 10, 1);
		table_row(OP_GET, 2, 1'b1, ST_OK, 13, 0);               // first free record
		table_row(OP_BEGIN_ADD, 4093, 1'b1, ST_FULL);
		table_row(OP_BEGIN_ADD, 4077, 1'b1, ST_OK, 11);         // fills up to the top
		table_row(OP_GET, 5);     // last record sits at the top byte: wrapped offset, zero length
		table_row(OP_GET, 2047);
		foreach (directed_rows[k])
			send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);

		// random phases, each at its own pool size, extremes and clamp cases first
		for (int p = 0; p < PHASES; p++) begin
			drain_and_settle();
			case (p)
				0:       sz = 0;
				1:       sz = 4;
				2:       sz = 8191;
				3:       sz = POOL_BYTES;
				4:       sz = 5;
				5, 6:    sz = $urandom_range(6, 600);
				7:       sz = $urandom_range(601, POOL_BYTES);
				default: sz = $urandom_range(POOL_BYTES + 1, 8191);
			endcase
			write_pool_size(sz);
			clr    = random_command();
			clr.op = OP_CLEAR;
			send_cmd(clr, 1'b0, none);
			run_phase(PHASE_ITEMS);
		end

		drain_and_settle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
